/* hw/rtl/daq_pkg.sv */
// Package for the delayed action queue: commands, result kinds, the stored entry
// layout and the result beat layout.
// No dependencies; daq_scan and delayed_action_queue import it.
`timescale 1ns / 1ps
`default_nettype none

package daq_pkg;

  localparam int DEF_CAPACITY = 16;
  localparam int MAX_RESULTS  = 16;
  localparam int FIRE_W       = $clog2(MAX_RESULTS + 1);

  localparam int HANDLE_W = 16;
  localparam int DELAY_W  = 31;
  localparam int CLOCK_W  = 32;
  localparam int PERIOD_W = 16;
  localparam int CMD_W    = 2;
  localparam int KIND_W   = 2;
  localparam int PEND_W   = 5;
  localparam int PEND_MAX = 31;

  localparam logic [PERIOD_W-1:0] TICK_RESET = 16'd100;

  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  localparam logic [KIND_W-1:0] KIND_ADD   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FIRED = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [CLOCK_W-1:0]  created;
    logic [DELAY_W-1:0]  delay;
  } entry_t;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [HANDLE_W-1:0] handle;
    logic                accepted;
    logic                last;
    logic [PEND_W-1:0]   pending;
  } result_t;

endpackage

`default_nettype wire

/* hw/rtl/daq_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered
// read data. No package dependency.
`timescale 1ns / 1ps
`default_nettype none

module daq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                     clk,
  input  wire logic                                     wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                         wr_data,
  input  wire logic                                     rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/daq_scan.sv */
// Command sequencer of the delayed action queue: millisecond clock, entry count,
// the tick scan over the entry memory and the result output register.
// Depends on daq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module daq_scan
  import daq_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY,
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [CMD_W-1:0]    in_cmd,
  input  wire logic [HANDLE_W-1:0] in_handle,
  input  wire logic [DELAY_W-1:0]  in_delay,
  input  wire logic [PERIOD_W-1:0] period,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output result_t                  out_res,
  output logic                     ram_wr_en,
  output logic [AW-1:0]            ram_wr_addr,
  output entry_t                   ram_wr_data,
  output logic                     ram_rd_en,
  output logic [AW-1:0]            ram_rd_addr,
  input  entry_t                   ram_rd_data
);

  localparam int SW = (CW > PEND_W) ? CW : PEND_W;

  state_t              state_r, state_nxt;
  logic [CLOCK_W-1:0]  clock_r, clock_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       rd_r, rd_nxt;
  logic [CW-1:0]       wr_r, wr_nxt;
  logic [FIRE_W-1:0]   nfire_r, nfire_nxt;
  logic                held_valid_r, held_valid_nxt;
  logic [HANDLE_W-1:0] held_handle_r, held_handle_nxt;
  logic [PEND_W-1:0]   held_pend_r, held_pend_nxt;
  logic                out_valid_r, out_valid_nxt;
  result_t             out_r, out_nxt;

  logic                out_free;
  logic                accept;
  logic [CLOCK_W-1:0]  elapsed;
  logic                fire;
  logic                stall;
  logic                last_entry;
  logic [CW-1:0]       rd_inc;
  logic [CW-1:0]       pend_full;
  logic [SW-1:0]       pend_ext;
  logic [PEND_W-1:0]   pend_sat;
  logic [SW-1:0]       count_ext;
  logic [PEND_W-1:0]   count_sat;
  logic                add_ok;
  logic [CW-1:0]       add_count;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE) && out_free;
  assign accept   = in_valid && in_ready;

  // Elapsed time is taken modulo 2^32, so it survives one wrap of the clock.
  assign elapsed    = clock_r - ram_rd_data.created;
  assign fire       = (nfire_r < FIRE_W'(MAX_RESULTS)) &&
                      (elapsed >= {1'b0, ram_rd_data.delay});
  // A second firing needs the output register for the one held before it.
  assign stall      = fire && held_valid_r && !out_free;
  assign rd_inc     = rd_r + CW'(1);
  assign last_entry = (rd_inc == count_r);

  // Entries left after this firing: survivors so far plus those not yet scanned.
  assign pend_full = wr_r + (count_r - rd_inc);
  assign pend_ext  = SW'(pend_full);
  assign pend_sat  = (pend_ext > SW'(PEND_MAX)) ? PEND_W'(PEND_MAX) : pend_ext[PEND_W-1:0];

  assign add_ok    = (count_r < CW'(CAPACITY));
  assign add_count = add_ok ? (count_r + CW'(1)) : count_r;
  assign count_ext = SW'(add_count);
  assign count_sat = (count_ext > SW'(PEND_MAX)) ? PEND_W'(PEND_MAX) : count_ext[PEND_W-1:0];

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_cmd == CMD_TICK) && (count_r != '0)) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!stall && last_entry) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!held_valid_r || out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath, memory accesses and result beats.
  always_comb begin
    clock_nxt       = clock_r;
    count_nxt       = count_r;
    rd_nxt          = rd_r;
    wr_nxt          = wr_r;
    nfire_nxt       = nfire_r;
    held_valid_nxt  = held_valid_r;
    held_handle_nxt = held_handle_r;
    held_pend_nxt   = held_pend_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_nxt         = out_r;
    ram_wr_en       = 1'b0;
    ram_wr_addr     = count_r[AW-1:0];
    ram_wr_data     = '{handle: in_handle, created: clock_r, delay: in_delay};
    ram_rd_en       = 1'b0;
    ram_rd_addr     = '0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_cmd)
            CMD_ADD: begin
              ram_wr_en     = add_ok;
              count_nxt     = add_count;
              out_valid_nxt = 1'b1;
              out_nxt       = '{kind: KIND_ADD, handle: in_handle, accepted: add_ok,
                                last: 1'b1, pending: count_sat};
            end
            CMD_TICK: begin
              clock_nxt      = clock_r + CLOCK_W'(period);
              rd_nxt         = '0;
              wr_nxt         = '0;
              nfire_nxt      = '0;
              held_valid_nxt = 1'b0;
              ram_rd_en      = (count_r != '0);
            end
            CMD_CLEAR: begin
              count_nxt     = '0;
              out_valid_nxt = 1'b1;
              out_nxt       = '{kind: KIND_CLEAR, handle: '0, accepted: 1'b0,
                                last: 1'b1, pending: '0};
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (!stall) begin
          if (fire) begin
            // The previous firing is known not to be the final one now.
            if (held_valid_r) begin
              out_valid_nxt = 1'b1;
              out_nxt       = '{kind: KIND_FIRED, handle: held_handle_r, accepted: 1'b0,
                                last: 1'b0, pending: held_pend_r};
            end
            held_valid_nxt  = 1'b1;
            held_handle_nxt = ram_rd_data.handle;
            held_pend_nxt   = pend_sat;
            nfire_nxt       = nfire_r + FIRE_W'(1);
          end else begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = wr_r[AW-1:0];
            ram_wr_data = ram_rd_data;
            wr_nxt      = wr_r + CW'(1);
          end
          rd_nxt = rd_inc;
          if (!last_entry) begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = rd_inc[AW-1:0];
          end
        end
      end
      ST_FLUSH: begin
        count_nxt = wr_r;
        if (held_valid_r && out_free) begin
          held_valid_nxt = 1'b0;
          out_valid_nxt  = 1'b1;
          out_nxt        = '{kind: KIND_FIRED, handle: held_handle_r, accepted: 1'b0,
                             last: 1'b1, pending: held_pend_r};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      clock_r      <= '0;
      count_r      <= '0;
      held_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clock_r      <= clock_nxt;
      count_r      <= count_nxt;
      held_valid_r <= held_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_r          <= rd_nxt;
    wr_r          <= wr_nxt;
    nfire_r       <= nfire_nxt;
    held_handle_r <= held_handle_nxt;
    held_pend_r   <= held_pend_nxt;
    out_r         <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

endmodule

`default_nettype wire

/* hw/rtl/delayed_action_queue.sv */
// Top level of the delayed action queue: stream ports, the tick period register,
// the entry memory and the command sequencer.
// Depends on daq_pkg, daq_ram and daq_scan.
`timescale 1ns / 1ps
`default_nettype none

// The block keeps up to CAPACITY pending actions in one entry memory (handle,
// creation time, delay) in arrival order. Add and clear beats each answer with
// one result beat. A tick beat advances the millisecond clock by tick_period_ms
// and then walks the stored entries through the memory's single read port, one
// entry per cycle while the result side does not stall, writing survivors back
// toward the head, and gives one beat per fired action with tlast on the final
// one (none if nothing fires). A new beat is taken only once the previous
// command is finished and the output register is free or being drained. The
// memory holds no reset state, so no clearing pass follows reset.
module delayed_action_queue
  import daq_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // action_handle[15:0], delay_ms[46:16], zero pad
  input  wire logic [1:0]  in_tuser,   // cmd[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // fired_handle[15:0], accepted[16],
                                       // pending_count[21:17], zero pad
  output logic [1:0]       out_tuser,  // kind[1:0]
  output logic             out_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data    // tick_period_ms[15:0]
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int EW = $bits(entry_t);

  logic [PERIOD_W-1:0] period_r;
  result_t             out_res;
  logic                ram_wr_en;
  logic [AW-1:0]       ram_wr_addr;
  entry_t              ram_wr_data;
  logic                ram_rd_en;
  logic [AW-1:0]       ram_rd_addr;
  entry_t              ram_rd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= TICK_RESET;
    end else if (cfg_valid) begin
      period_r <= cfg_data;
    end
  end

  daq_ram #(
    .WIDTH (EW),
    .DEPTH (CAPACITY)
  ) u_entries (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  daq_scan #(
    .CAPACITY (CAPACITY)
  ) u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_cmd      (in_tuser),
    .in_handle   (in_tdata[15:0]),
    .in_delay    (in_tdata[46:16]),
    .period      (period_r),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_res     (out_res),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data)
  );

  assign out_tdata = {2'b00, out_res.pending, out_res.accepted, out_res.handle};
  assign out_tuser = out_res.kind;
  assign out_tlast = out_res.last;

  // During a scan the write-back slot always trails the entry being fetched.
  a_no_rw_collision : assert property (@(posedge clk) disable iff (!rst_n)
    ram_wr_en && ram_rd_en |-> ram_wr_addr != ram_rd_addr)
    else $error("entry memory written and read at the same address");

  a_single_answer_last : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_res.kind != KIND_FIRED |-> out_res.last)
    else $error("add or clear answer without tlast");

  a_fired_not_accepted : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_res.kind != KIND_ADD |-> !out_res.accepted)
    else $error("accepted flag set on a non-add beat");

  a_no_take_while_busy : assert property (@(posedge clk) disable iff (!rst_n)
    ram_rd_en && !(in_tvalid && in_tready) |-> !in_tready)
    else $error("input taken while a scan is fetching entries");

endmodule

`default_nettype wire
